// File: rtl/wto_pkg.sv
// Package for the wavetable oscillator: table geometry, fixed-point widths,
// request codes and pipeline control types. No dependencies.
`timescale 1ns / 1ps
package wto_pkg;

	localparam int TABLE_SIZE  = 8192;
	localparam int FRAC_BITS   = 16;
	localparam int SAMPLE_BITS = 16;

	localparam int IDX_W   = $clog2(TABLE_SIZE);
	localparam int PHASE_W = IDX_W + FRAC_BITS;
	localparam int DIFF_W  = SAMPLE_BITS + 1;
	localparam int PROD_W  = DIFF_W + FRAC_BITS + 1;

	localparam logic [1:0] REQ_WRITE = 2'd0;
	localparam logic [1:0] REQ_SAMPLE = 2'd1;
	localparam logic [1:0] REQ_PHASE_RST = 2'd2;

	localparam logic REG_PHASE_STEP = 1'b0;
	localparam logic REG_INTERP_EN  = 1'b1;

	typedef struct packed {
		logic                 valid;
		logic                 interp;
		logic [FRAC_BITS-1:0] frac;
	} stage_ctl_t;

endpackage

// File: rtl/wto_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module wto_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 8192
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// File: rtl/wto_interp.sv
// Interpolation datapath: difference and fraction multiply (s2 register),
// then floor shift and add. Depends on wto_pkg.
`timescale 1ns / 1ps
module wto_interp import wto_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          adv,
	input  stage_ctl_t                    ctl_s1,
	input  logic signed [SAMPLE_BITS-1:0] a_s1,
	input  logic signed [SAMPLE_BITS-1:0] b_s1,
	output logic                          valid_s2,
	output logic signed [SAMPLE_BITS-1:0] result
);

	logic signed [DIFF_W-1:0]      diff;
	logic signed [PROD_W-1:0]      prod;
	logic signed [PROD_W-1:0]      prod_s2;
	logic signed [SAMPLE_BITS-1:0] a_s2;
	logic signed [PROD_W-1:0]      shifted;
	logic signed [SAMPLE_BITS-1:0] sum;

	assign diff = DIFF_W'(b_s1) - DIFF_W'(a_s1);
	assign prod = $signed({1'b0, ctl_s1.frac}) * diff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= ctl_s1.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			a_s2    <= a_s1;
			prod_s2 <= ctl_s1.interp ? prod : '0;
		end
	end

	// arithmetic shift gives the floor toward minus infinity
	assign shifted = prod_s2 >>> FRAC_BITS;
	assign sum     = a_s2 + SAMPLE_BITS'(shifted);
	assign result  = sum;

endmodule

// File: rtl/wavetable_oscillator_interp.sv
// Top level of the wavetable oscillator: request decode, phase accumulator,
// APB registers, table memories and output register. Depends on wto_pkg,
// wto_ram and wto_interp.
//
// Accepts one transaction per clock while the output register is empty or its
// sample is taken. A sample passes the table read at the accepting edge, the
// multiply into the s2 register and the add into the output register. The table
// is held in two identical RAM copies so the entry and its neighbor are read in
// the same cycle; entries read before they are written return undefined data.
// Phase wraps at the table length, and the last entry interpolates toward entry
// zero.
`timescale 1ns / 1ps
module wavetable_oscillator_interp import wto_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_ready,
	input  logic [1:0]                    req_type,
	input  logic [IDX_W-1:0]              table_index,
	input  logic signed [SAMPLE_BITS-1:0] table_value,
	output logic                          sample_valid,
	input  logic                          sample_ready,
	output logic signed [SAMPLE_BITS-1:0] sample,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [2:0]                    paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);

	logic [PHASE_W-1:0] step_q;
	logic               interp_en_q;
	logic [PHASE_W-1:0] phase_q;

	logic               adv;
	logic               accept;
	logic               do_write;
	logic               do_sample;
	logic [IDX_W-1:0]   base;
	logic [IDX_W-1:0]   next_idx;

	stage_ctl_t                    ctl_s1;
	logic signed [SAMPLE_BITS-1:0] a_s1;
	logic signed [SAMPLE_BITS-1:0] b_s1;
	logic                          valid_s2;
	logic signed [SAMPLE_BITS-1:0] result;

	logic                          out_valid_q;
	logic signed [SAMPLE_BITS-1:0] sample_q;

	assign adv       = !out_valid_q || sample_ready;
	assign req_ready = adv;
	assign accept    = req_valid && adv;
	assign do_write  = accept && (req_type == REQ_WRITE);
	assign do_sample = accept && (req_type == REQ_SAMPLE);
	assign base      = phase_q[PHASE_W-1:FRAC_BITS];
	assign next_idx  = base + IDX_W'(1);

	// APB registers
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= '0;
			interp_en_q <= 1'b1;
		end else if (psel && penable && pwrite && pready) begin
			unique case (paddr[2])
				REG_PHASE_STEP: step_q      <= pwdata[PHASE_W-1:0];
				REG_INTERP_EN:  interp_en_q <= pwdata[0];
				default:        ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_PHASE_STEP: prdata = {{(32-PHASE_W){1'b0}}, step_q};
			REG_INTERP_EN:  prdata = {31'd0, interp_en_q};
			default:        prdata = '0;
		endcase
	end

	// phase accumulator, wraps at the table length
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
		end else if (accept && (req_type == REQ_PHASE_RST)) begin
			phase_q <= '0;
		end else if (do_sample) begin
			phase_q <= phase_q + step_q;
		end
	end

	wto_ram #(
		.WIDTH(SAMPLE_BITS),
		.DEPTH(TABLE_SIZE)
	) u_ram_a (
		.clk     (clk),
		.wr_en   (do_write),
		.wr_addr (table_index),
		.wr_data (table_value),
		.rd_en   (do_sample),
		.rd_addr (base),
		.rd_data (a_s1)
	);

	wto_ram #(
		.WIDTH(SAMPLE_BITS),
		.DEPTH(TABLE_SIZE)
	) u_ram_b (
		.clk     (clk),
		.wr_en   (do_write),
		.wr_addr (table_index),
		.wr_data (table_value),
		.rd_en   (do_sample),
		.rd_addr (next_idx),
		.rd_data (b_s1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			if (adv) begin
				ctl_s1.valid <= do_sample;
			end
			if (do_sample) begin
				ctl_s1.interp <= interp_en_q;
				ctl_s1.frac   <= phase_q[FRAC_BITS-1:0];
			end
		end
	end

	wto_interp u_interp (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.ctl_s1   (ctl_s1),
		.a_s1     (a_s1),
		.b_s1     (b_s1),
		.valid_s2 (valid_s2),
		.result   (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s2) begin
			sample_q <= result;
		end
	end

	assign sample_valid = out_valid_q;
	assign sample       = sample_q;

	// checks
	a_ready_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!req_ready |-> (sample_valid && !sample_ready))
		else $error("request stalled without output backpressure");

	a_phase_rst: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready && req_type == REQ_PHASE_RST) |=> (phase_q == '0))
		else $error("phase not cleared");

	a_phase_adv: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready && req_type == REQ_SAMPLE)
		|=> (phase_q == PHASE_W'($past(phase_q) + $past(step_q))))
		else $error("phase did not advance by the step");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl_s1.valid && !adv) |=> ctl_s1.valid)
		else $error("stage one item lost under stall");

endmodule
